// ----- rtl/core/bwct_pkg.sv -----
// Package for the block wear counter table: item types, operation codes, limits.
`default_nettype none

package bwct_pkg;

    // Operation codes carried in the input item
    localparam logic [2:0] OP_RECORD  = 3'd0;
    localparam logic [2:0] OP_READ    = 3'd1;
    localparam logic [2:0] OP_FIND    = 3'd2;
    localparam logic [2:0] OP_TOTAL   = 3'd3;
    localparam logic [2:0] OP_SET_USE = 3'd4;

    // Saturation limits
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [27:0] TOTAL_MAX = 28'hFFF_FFFF;

    // Input item
    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] block_index;
        logic        in_use;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic        valid_res;
        logic [15:0] wear_count;
        logic [11:0] found_block;
        logic [27:0] total_writes;
    } t_out_item;

    // One table entry: in-use flag and wear counter
    typedef struct packed {
        logic        used;
        logic [15:0] count;
    } t_entry;

endpackage

`default_nettype wire

// ----- rtl/core/bwct_chan_if.sv -----
// Valid/ready channel interface carrying one item of a given payload type.
`default_nettype none

interface bwct_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/block_wear_counter_table.sv -----
// Wear counter table: per-block saturating write counters and in-use flags in one RAM.
// Record, read and set-usage read the entry on accept, then in S_ACCESS write it back (record and set-usage)
// and register the result. Out-of-range indexes and unused codes answer in the cycle after accept.
// Find and total walk the RAM through its single read port, one entry per cycle; find walks from
// the given index to the last entry before the reserved tail, total walks every entry. One item is in work at a time.
// After reset a clearing pass writes zero to every entry; no item is taken meanwhile.
`default_nettype none

module block_wear_counter_table #(
    parameter int BLOCKS        = 4096,
    parameter int TAIL_RESERVED = 2
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bwct_chan_if.sink   i_in,
    bwct_chan_if.source o_out
);
    import bwct_pkg::*;

    localparam int AW    = $clog2(BLOCKS);
    localparam int END_I = (TAIL_RESERVED < BLOCKS) ? (BLOCKS - TAIL_RESERVED) : 0;
    localparam logic [AW-1:0] LAST_FIND  = AW'((END_I > 0) ? (END_I - 1) : 0);
    localparam logic [AW-1:0] LAST_BLOCK = AW'(BLOCKS - 1);

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_ACCESS = 4'b0100,
        S_SCAN   = 4'b1000
    } t_state;

    // Control and working registers
    t_state      r_state,   n_state;
    logic [AW-1:0] r_addr,  n_addr;
    logic [AW-1:0] r_last,  n_last;
    logic        r_issuing, n_issuing;
    logic        r_rd_vld,  n_rd_vld;
    logic        r_rd_last, n_rd_last;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [2:0]  r_op,      n_op;
    logic        r_flag,    n_flag;
    logic        r_found,   n_found;
    logic [AW-1:0] r_best_idx, n_best_idx;
    logic [15:0] r_best_cnt, n_best_cnt;
    logic [27:0] r_sum,     n_sum;
    t_out_item   r_out,     n_out;
    logic        r_out_valid, n_out_valid;

    // Table RAM
    t_entry      r_mem [BLOCKS];
    t_entry      r_rd_data;
    logic        s_we;
    logic [AW-1:0] s_wr_addr;
    t_entry      s_wr_data;
    logic [AW-1:0] s_rd_addr;

    t_in_item    s_in;
    logic        s_in_acc;
    logic        s_in_range;
    logic        s_find_ok;
    logic        s_take;
    logic [28:0] s_sum_ext;
    logic [27:0] s_sum_sat;
    logic [15:0] s_inc;
    logic [31:0] s_best_ext;

    assign s_in       = i_in.payload;
    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign s_in_acc   = i_in.valid && i_in.ready;
    assign s_in_range = {1'b0, s_in.block_index} < 17'(BLOCKS);
    assign s_find_ok  = {1'b0, s_in.block_index} < 17'(END_I);

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // RAM read address: request index while idle, walking address otherwise
    assign s_rd_addr = (r_state == S_IDLE) ? s_in.block_index[AW-1:0] : r_addr;

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_mem[s_wr_addr] <= s_wr_data;
        end
        r_rd_data <= r_mem[s_rd_addr];
    end

    // Scan datapath: least-worn candidate and saturating sum
    assign s_take = r_rd_vld && !r_rd_data.used
                    && (!r_found || (r_rd_data.count < r_best_cnt));
    assign s_sum_ext = {1'b0, r_sum} + 29'(r_rd_data.count);
    assign s_sum_sat = s_sum_ext[28] ? TOTAL_MAX : s_sum_ext[27:0];
    assign s_inc     = (r_rd_data.count == COUNT_MAX) ? COUNT_MAX : r_rd_data.count + 16'd1;

    // Next state and RAM write control
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_last      = r_last;
        n_issuing   = r_issuing;
        n_rd_vld    = 1'b0;
        n_rd_last   = r_rd_last;
        n_rd_idx    = r_rd_idx;
        n_op        = r_op;
        n_flag      = r_flag;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_cnt  = r_best_cnt;
        n_sum       = r_sum;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        s_we        = 1'b0;
        s_wr_addr   = r_addr;
        s_wr_data   = '0;
        s_best_ext  = '0;

        case (r_state)
            // zero every entry after reset
            S_CLEAR: begin
                s_we = 1'b1;
                if (r_addr == LAST_BLOCK) begin
                    n_state = S_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end

            // decode an accepted item
            S_IDLE: begin
                if (s_in_acc) begin
                    n_op   = s_in.operation;
                    n_flag = s_in.in_use;
                    n_addr = s_in.block_index[AW-1:0];
                    n_out  = '0;
                    case (s_in.operation)
                        OP_RECORD, OP_READ, OP_SET_USE: begin
                            if (s_in_range) begin
                                n_state = S_ACCESS;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        OP_FIND: begin
                            if (s_find_ok) begin
                                n_state   = S_SCAN;
                                n_last    = LAST_FIND;
                                n_issuing = 1'b1;
                                n_found   = 1'b0;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        OP_TOTAL: begin
                            n_state   = S_SCAN;
                            n_addr    = '0;
                            n_last    = LAST_BLOCK;
                            n_issuing = 1'b1;
                            n_sum     = '0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end

            // read data is here: modify and write back (record, set-usage), answer
            S_ACCESS: begin
                n_out           = '0;
                n_out.valid_res = 1'b1;
                n_out_valid     = 1'b1;
                n_state         = S_IDLE;
                case (r_op)
                    OP_RECORD: begin
                        s_we             = 1'b1;
                        s_wr_data.used   = r_rd_data.used;
                        s_wr_data.count  = s_inc;
                        n_out.wear_count = s_inc;
                    end
                    OP_SET_USE: begin
                        s_we             = 1'b1;
                        s_wr_data.used   = r_flag;
                        s_wr_data.count  = r_rd_data.count;
                        n_out.wear_count = r_rd_data.count;
                    end
                    default: begin
                        n_out.wear_count = r_rd_data.count;
                    end
                endcase
            end

            // walk entries: issue one read a cycle, fold in the returned one
            S_SCAN: begin
                if (r_issuing) begin
                    n_rd_vld  = 1'b1;
                    n_rd_idx  = r_addr;
                    n_rd_last = (r_addr == r_last);
                    if (r_addr == r_last) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
                if (r_rd_vld) begin
                    if (s_take) begin
                        n_found    = 1'b1;
                        n_best_idx = r_rd_idx;
                        n_best_cnt = r_rd_data.count;
                    end
                    n_sum = s_sum_sat;
                end
                if (r_rd_vld && r_rd_last) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    if (r_op == OP_TOTAL) begin
                        n_out.valid_res    = 1'b1;
                        n_out.total_writes = s_sum_sat;
                    end else if (n_found) begin
                        s_best_ext        = 32'(n_best_idx);
                        n_out.valid_res   = 1'b1;
                        n_out.wear_count  = n_best_cnt;
                        n_out.found_block = s_best_ext[11:0];
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_issuing   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_issuing   <= n_issuing;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
        r_last     <= n_last;
        r_rd_last  <= n_rd_last;
        r_rd_idx   <= n_rd_idx;
        r_op       <= n_op;
        r_flag     <= n_flag;
        r_found    <= n_found;
        r_best_idx <= n_best_idx;
        r_best_cnt <= n_best_cnt;
        r_sum      <= n_sum;
        r_out      <= n_out;
    end

    // Returned scan data only arrives while scanning
    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_SCAN))
        else $error("scan read data outside scan");

    // Scans never modify the table
    a_no_write_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !s_we)
        else $error("table written during scan");

    // An access returns to idle with a result in the cycle after it
    a_access_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACCESS) |=> ((r_state == S_IDLE) && r_out_valid))
        else $error("access did not produce a result");

    // No item accepted while a walk is still issuing reads
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issuing |-> !i_in.ready)
        else $error("input ready during scan");

endmodule

`default_nettype wire
